>>> src/tdpcm_pkg.sv
// Shared types, constants and the step table of the table-driven DPCM audio decoder.
package tdpcm_pkg;

    // Largest number of interleaved channels that the decoder holds state for.
    localparam int MAX_CHANNELS = 2;
    localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    localparam int CODE_W       = 8;
    localparam int SAMPLE_W     = 16;
    localparam int STEP_IDX_W   = 6;
    localparam int LITERAL_SHIFT = 9;
    localparam int LITERAL_BIT  = 7;
    localparam int SIGN_BIT     = 6;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int COUNT_REG_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_STEP_SCALE    = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0]    eff_count;
        logic [SAMPLE_W-1:0] step_scale;
    } cfg_t;

    function automatic logic [SAMPLE_W-1:0] step_lookup(input logic [STEP_IDX_W-1:0] idx);
        logic [SAMPLE_W-1:0] s;
        case (idx)
            6'd0:  s = 16'h0000;  6'd1:  s = 16'h0002;  6'd2:  s = 16'h0004;
            6'd3:  s = 16'h0006;  6'd4:  s = 16'h0008;  6'd5:  s = 16'h000A;
            6'd6:  s = 16'h000C;  6'd7:  s = 16'h000F;  6'd8:  s = 16'h0012;
            6'd9:  s = 16'h0015;  6'd10: s = 16'h0018;  6'd11: s = 16'h001C;
            6'd12: s = 16'h0020;  6'd13: s = 16'h0024;  6'd14: s = 16'h0028;
            6'd15: s = 16'h002C;  6'd16: s = 16'h0031;  6'd17: s = 16'h0036;
            6'd18: s = 16'h003B;  6'd19: s = 16'h0040;  6'd20: s = 16'h0046;
            6'd21: s = 16'h004C;  6'd22: s = 16'h0052;  6'd23: s = 16'h0058;
            6'd24: s = 16'h005F;  6'd25: s = 16'h0066;  6'd26: s = 16'h006D;
            6'd27: s = 16'h0074;  6'd28: s = 16'h007C;  6'd29: s = 16'h0084;
            6'd30: s = 16'h008C;  6'd31: s = 16'h0094;  6'd32: s = 16'h00A0;
            6'd33: s = 16'h00AA;  6'd34: s = 16'h00B4;  6'd35: s = 16'h00BE;
            6'd36: s = 16'h00C8;  6'd37: s = 16'h00D2;  6'd38: s = 16'h00DC;
            6'd39: s = 16'h00E6;  6'd40: s = 16'h00F0;  6'd41: s = 16'h00FF;
            6'd42: s = 16'h010E;  6'd43: s = 16'h011D;  6'd44: s = 16'h012C;
            6'd45: s = 16'h0140;  6'd46: s = 16'h0154;  6'd47: s = 16'h0168;
            6'd48: s = 16'h017C;  6'd49: s = 16'h0190;  6'd50: s = 16'h01A9;
            6'd51: s = 16'h01C2;  6'd52: s = 16'h01DB;  6'd53: s = 16'h01F4;
            6'd54: s = 16'h020D;  6'd55: s = 16'h0226;  6'd56: s = 16'h0244;
            6'd57: s = 16'h0262;  6'd58: s = 16'h028A;  6'd59: s = 16'h02BC;
            6'd60: s = 16'h02EE;  6'd61: s = 16'h0320;  6'd62: s = 16'h0384;
            default: s = 16'h03E8;
        endcase
        return s;
    endfunction

endpackage

>>> src/tdpcm_cfg.sv
// Configuration registers and the derived effective channel count.
module tdpcm_cfg
    import tdpcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [COUNT_REG_W-1:0] count_reg;
    logic [SAMPLE_W-1:0]    scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_REG_W'(1);
            scale_reg <= SAMPLE_W'(1);
        end else if (wr_en) begin
            unique case (wr_index)
                REG_CHANNEL_COUNT: count_reg <= wr_data[COUNT_REG_W-1:0];
                REG_STEP_SCALE:    scale_reg <= wr_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero means one channel; counts beyond the held state saturate.
    always_comb begin
        if (count_reg == '0) begin
            cfg.eff_count = CNT_W'(1);
        end else if (32'(count_reg) > 32'(MAX_CHANNELS)) begin
            cfg.eff_count = CNT_W'(MAX_CHANNELS);
        end else begin
            cfg.eff_count = CNT_W'(count_reg);
        end
        cfg.step_scale = scale_reg;
    end

endmodule

>>> src/tdpcm_datapath.sv
// Per-channel sample state, channel rotation and the step decode arithmetic.
module tdpcm_datapath
    import tdpcm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [CODE_W-1:0]   code,
    input  cfg_t                cfg,
    output logic [SAMPLE_W-1:0] sample,
    output logic [CH_W-1:0]     channel
);

    logic [SAMPLE_W-1:0]   last_reg [MAX_CHANNELS];
    logic [CH_W-1:0]       ch_reg;
    logic [CH_W-1:0]       ch_next;
    logic [CH_W-1:0]       ch_sel;
    logic [CNT_W-1:0]      ch_inc;
    logic [SAMPLE_W-1:0]   step;
    logic [2*SAMPLE_W-1:0] product;

    // The pointer may sit beyond a count lowered since the last item.
    assign ch_sel = (CNT_W'(ch_reg) >= cfg.eff_count) ? '0 : ch_reg;
    assign ch_inc = CNT_W'(ch_sel) + CNT_W'(1);
    assign ch_next = (ch_inc >= cfg.eff_count) ? '0 : ch_inc[CH_W-1:0];

    always_comb begin
        step = step_lookup(code[STEP_IDX_W-1:0]);
        if (code[SIGN_BIT]) begin
            step = SAMPLE_W'(0) - step;
        end
        product = (2*SAMPLE_W)'(step) * (2*SAMPLE_W)'(cfg.step_scale);
        if (code[LITERAL_BIT]) begin
            sample = SAMPLE_W'({code[LITERAL_BIT-1:0], {LITERAL_SHIFT{1'b0}}});
        end else begin
            sample = last_reg[ch_sel] + product[SAMPLE_W-1:0];
        end
    end

    assign channel = ch_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                last_reg[i] <= '0;
            end
        end else if (advance) begin
            ch_reg           <= ch_next;
            last_reg[ch_sel] <= sample;
        end
    end

endmodule

>>> src/table_dpcm_audio_decoder_top.sv
// Top level of the table-driven DPCM audio decoder with its stream registers.
//
// Code bytes arrive on the s_ stream, one channel-interleaved byte per transaction,
// and each gives one 16-bit PCM sample on the m_ stream, with its channel in m_tuser.
// A byte is held in an input register; the table lookup, the 16x16 multiply and the
// add to the channel's previous sample sit between that register and the output
// register, from which the sample is presented. One byte per cycle is sustained
// while m_tready is high: the input register hands over to the output register
// whenever that is empty or being taken in the same cycle, and the channel state is
// updated at that hand-over, so the following byte sees it at once.
// When the receiver stalls, one sample waits in the output register and one byte in
// the input register; s_tready falls only when both are full.
// The cfg_ channel writes channel_count (index 0) or step_scale (index 1); it is
// always ready and should only be used while no transaction is in flight.
// Synchronous reset empties both stream registers, clears all previous samples and
// the channel pointer, and sets channel_count and step_scale to one.
module table_dpcm_audio_decoder_top
    import tdpcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] code_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] pcm_sample
    output logic                  m_tuser,   // [0] channel_index
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                in_valid_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                chan_reg;
    logic                move;
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     channel;
    cfg_t                cfg;

    assign cfg_ready = 1'b1;
    assign move      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || move;

    tdpcm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    tdpcm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (move),
        .code    (code_reg),
        .cfg     (cfg),
        .sample  (sample),
        .channel (channel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            code_reg <= s_tdata;
        end
        if (move) begin
            sample_reg <= sample;
            chan_reg   <= channel[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sample_reg;
    assign m_tuser  = chan_reg;

`ifndef SYNTHESIS
    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted transaction not held in input register");

    a_input_waits_only_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !move |-> out_valid_reg && !m_tready)
        else $error("input register stalled with output free");

    a_move_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> m_tvalid)
        else $error("decoded sample not presented");
`endif

endmodule
